// ===== rtl/plim_pkg.sv =====
// Shared widths, command codes and controller states of the piecewise linear interpolator.
package plim_pkg;

    localparam int DATA_W         = 32;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int FRAC_W         = 16;
    localparam int DEF_MAX_POINTS = 1024;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_END0,
        S_END1,
        S_DOWN,
        S_UP,
        S_DIFF,
        S_FRAC,
        S_DIV,
        S_MUL,
        S_SUM,
        S_OUT
    } plim_state_t;

endpackage

// ===== rtl/plim_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module plim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plim_div.sv =====
// Restoring divider that forms a 16-bit fraction num/den, one quotient bit per cycle.
module plim_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [plim_pkg::DATA_W-1:0] num,
    input  logic [plim_pkg::DATA_W-1:0] den,
    output logic                        done,
    output logic [plim_pkg::FRAC_W-1:0] quot
);

    import plim_pkg::*;

    localparam int STEP_W = $clog2(FRAC_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic [FRAC_W-1:0] quot_reg, quot_next;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              fits;

    always_comb
    begin
        rem_shift  = {rem_reg, 1'b0};
        rem_diff   = rem_shift - {1'b0, den_reg};
        fits       = rem_shift >= {1'b0, den_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(FRAC_W);
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
            quot_next = {quot_reg[FRAC_W-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator: table memory, segment walk and arithmetic.
//
// Input channel (in_valid/in_stall): cmd selects a load of one table point or a query.
// A load writes the point memory when point_index is below MAX_POINTS and gives no result.
// A query gives one result on the output channel (out_valid/out_stall) with value_y,
// segment and empty_res. An empty table answers without a memory read, a clamp at the first
// point after reading entry 0, and a clamp at the last point after reading entries 0 and last.
// An interpolated query then walks the table from the last used segment, with one
// memory read per walk step, and goes on through the difference, fraction, multiply
// and sum steps. The fraction division is bit-serial and is skipped
// when the fraction is 0 or 1.0.
// Items are taken one at a time: in_stall is high while a query is in progress.
// A finished result waits in the output register while the next item is accepted;
// if the receiver stalls, a second result is held back until the first transfer.
// The point count is written through cfg_valid/cfg_ready while the block is idle.
// Reset clears the point count, the segment hint and the output valid; the point
// memory is not cleared and an entry must be loaded before a query reads it.
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = plim_pkg::DEF_MAX_POINTS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [plim_pkg::CNT_W-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic        [plim_pkg::IDX_W-1:0]  point_index,
    input  logic signed [plim_pkg::DATA_W-1:0] point_x,
    input  logic signed [plim_pkg::DATA_W-1:0] point_y,
    input  logic signed [plim_pkg::DATA_W-1:0] query_x,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [plim_pkg::DATA_W-1:0] value_y,
    output logic        [plim_pkg::IDX_W-1:0]  segment,
    output logic                               empty_res
);

    import plim_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int CW   = AW + 1;
    localparam int ENT_W = 2 * DATA_W;
    localparam int R_W  = FRAC_W + 1;
    localparam int D_W  = DATA_W + 1;
    localparam int P_W  = R_W + 1 + D_W;

    plim_state_t state_reg, state_next;

    logic [CNT_W-1:0] point_count_reg, point_count_next;
    logic [IDX_W-1:0] hint_reg, hint_next;
    logic             out_valid_reg, out_valid_next;

    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] x0_reg, x0_next;
    logic signed [DATA_W-1:0] y0_reg, y0_next;
    logic signed [DATA_W-1:0] lx_reg, lx_next;
    logic signed [DATA_W-1:0] ly_reg, ly_next;
    logic signed [DATA_W-1:0] rx_reg, rx_next;
    logic signed [DATA_W-1:0] ry_reg, ry_next;
    logic        [AW-1:0]     j_reg, j_next;
    logic signed [D_W-1:0]    num_reg, num_next;
    logic signed [D_W-1:0]    den_reg, den_next;
    logic signed [D_W-1:0]    dy_reg, dy_next;
    logic        [R_W-1:0]    r_reg, r_next;
    logic signed [P_W-1:0]    prod_reg, prod_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    logic        [AW-1:0]     res_seg_reg, res_seg_next;
    logic                     res_empty_reg, res_empty_next;
    logic signed [DATA_W-1:0] value_y_reg, value_y_next;
    logic        [IDX_W-1:0]  segment_reg, segment_next;
    logic                     empty_res_reg, empty_res_next;

    logic [CW-1:0]     n_pts;
    logic [AW-1:0]     last_idx;
    logic [AW-1:0]     j_start;
    logic              in_accept;
    logic              ram_en;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [ENT_W-1:0]  ram_rdata;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_y;
    logic              div_start;
    logic              div_done;
    logic [FRAC_W-1:0] div_quot;

    plim_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    plim_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg[DATA_W-1:0]),
        .den   (den_reg[DATA_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign rd_x      = $signed(ram_rdata[ENT_W-1:DATA_W]);
    assign rd_y      = $signed(ram_rdata[DATA_W-1:0]);
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        if (32'(point_count_reg) > 32'(MAX_POINTS))
        begin
            n_pts = CW'(MAX_POINTS);
        end
        else
        begin
            n_pts = CW'(point_count_reg);
        end
        last_idx = AW'(n_pts - CW'(1));
        if (32'(hint_reg) > 32'(last_idx))
        begin
            j_start = last_idx;
        end
        else
        begin
            j_start = AW'(hint_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        point_count_next = point_count_reg;
        hint_next        = hint_reg;
        out_valid_next   = out_valid_reg;
        x_next           = x_reg;
        x0_next          = x0_reg;
        y0_next          = y0_reg;
        lx_next          = lx_reg;
        ly_next          = ly_reg;
        rx_next          = rx_reg;
        ry_next          = ry_reg;
        j_next           = j_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        dy_next          = dy_reg;
        r_next           = r_reg;
        prod_next        = prod_reg;
        res_value_next   = res_value_reg;
        res_seg_next     = res_seg_reg;
        res_empty_next   = res_empty_reg;
        value_y_next     = value_y_reg;
        segment_next     = segment_reg;
        empty_res_next   = empty_res_reg;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = '0;
        ram_wdata        = {point_x, point_y};
        div_start        = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            point_count_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_LOAD)
                    begin
                        if (32'(point_index) < 32'(MAX_POINTS))
                        begin
                            ram_en   = 1'b1;
                            ram_we   = 1'b1;
                            ram_addr = AW'(point_index);
                        end
                    end
                    else
                    begin
                        x_next = query_x;
                        if (n_pts == '0)
                        begin
                            res_value_next = '0;
                            res_seg_next   = '0;
                            res_empty_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            ram_en     = 1'b1;
                            ram_addr   = '0;
                            state_next = S_END0;
                        end
                    end
                end
            end
            S_END0:
            begin
                x0_next = rd_x;
                y0_next = rd_y;
                if (x_reg <= rd_x)
                begin
                    res_value_next = rd_y;
                    res_seg_next   = '0;
                    res_empty_next = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    ram_en     = 1'b1;
                    ram_addr   = last_idx;
                    state_next = S_END1;
                end
            end
            S_END1:
            begin
                if (x_reg >= rd_x)
                begin
                    res_value_next = rd_y;
                    res_seg_next   = last_idx;
                    res_empty_next = 1'b0;
                    state_next     = S_OUT;
                end
                else
                begin
                    j_next = j_start;
                    ram_en = 1'b1;
                    if (j_start == '0)
                    begin
                        lx_next    = x0_reg;
                        ly_next    = y0_reg;
                        ram_addr   = AW'(1);
                        state_next = S_UP;
                    end
                    else
                    begin
                        ram_addr   = j_start;
                        state_next = S_DOWN;
                    end
                end
            end
            S_DOWN:
            begin
                ram_en = 1'b1;
                if (x_reg < rd_x)
                begin
                    j_next = j_reg - AW'(1);
                    if (j_reg == AW'(1))
                    begin
                        lx_next    = x0_reg;
                        ly_next    = y0_reg;
                        ram_addr   = AW'(1);
                        state_next = S_UP;
                    end
                    else
                    begin
                        ram_addr = j_reg - AW'(1);
                    end
                end
                else
                begin
                    lx_next    = rd_x;
                    ly_next    = rd_y;
                    ram_addr   = j_reg + AW'(1);
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (x_reg > rd_x)
                begin
                    j_next   = j_reg + AW'(1);
                    lx_next  = rd_x;
                    ly_next  = rd_y;
                    ram_en   = 1'b1;
                    ram_addr = j_reg + AW'(2);
                end
                else
                begin
                    rx_next    = rd_x;
                    ry_next    = rd_y;
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                num_next   = {x_reg[DATA_W-1], x_reg} - {lx_reg[DATA_W-1], lx_reg};
                den_next   = {rx_reg[DATA_W-1], rx_reg} - {lx_reg[DATA_W-1], lx_reg};
                dy_next    = {ry_reg[DATA_W-1], ry_reg} - {ly_reg[DATA_W-1], ly_reg};
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                if (num_reg <= $signed(D_W'(0)) || den_reg <= $signed(D_W'(0)))
                begin
                    r_next     = '0;
                    state_next = S_MUL;
                end
                else if (num_reg >= den_reg)
                begin
                    r_next     = R_W'(1) << FRAC_W;
                    state_next = S_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    r_next     = {1'b0, div_quot};
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = $signed({1'b0, r_reg}) * dy_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                res_value_next = ly_reg + prod_reg[DATA_W+FRAC_W-1:FRAC_W];
                res_seg_next   = j_reg;
                res_empty_next = 1'b0;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_y_next   = res_value_reg;
                    segment_next   = IDX_W'(res_seg_reg);
                    empty_res_next = res_empty_reg;
                    if (!res_empty_reg)
                    begin
                        hint_next = IDX_W'(res_seg_reg);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            hint_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            hint_reg        <= hint_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        x0_reg        <= x0_next;
        y0_reg        <= y0_next;
        lx_reg        <= lx_next;
        ly_reg        <= ly_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        j_reg         <= j_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        dy_reg        <= dy_next;
        r_reg         <= r_next;
        prod_reg      <= prod_next;
        res_value_reg <= res_value_next;
        res_seg_reg   <= res_seg_next;
        res_empty_reg <= res_empty_next;
        value_y_reg   <= value_y_next;
        segment_reg   <= segment_next;
        empty_res_reg <= empty_res_next;
    end

    assign out_valid = out_valid_reg;
    assign value_y   = value_y_reg;
    assign segment   = segment_reg;
    assign empty_res = empty_res_reg;

endmodule

// ===== tb/piecewise_linear_interpolator_test.sv =====
// Self-checking testbench for the piecewise linear interpolator with a scoreboard class.

class ordinate_scoreboard;

    typedef struct packed {
        logic signed [plim_pkg::DATA_W-1:0] value;
        logic        [plim_pkg::IDX_W-1:0]  seg;
        logic                               empty;
    } ordinate_t;

    logic signed [plim_pkg::DATA_W-1:0] knot_x [plim_pkg::DEF_MAX_POINTS];
    logic signed [plim_pkg::DATA_W-1:0] knot_y [plim_pkg::DEF_MAX_POINTS];
    int unsigned point_count;
    int unsigned segment_hint;
    ordinate_t   expected_ordinates [$];
    int          mismatches;

    function new();
        point_count  = 0;
        segment_hint = 0;
        mismatches   = 0;
    endfunction

    function void set_count(input int unsigned count);
        point_count = count;
    endfunction

    function int pending();
        return expected_ordinates.size();
    endfunction

    function void note_input(input logic c, input logic [plim_pkg::IDX_W-1:0] idx,
                             input logic signed [plim_pkg::DATA_W-1:0] px,
                             input logic signed [plim_pkg::DATA_W-1:0] py,
                             input logic signed [plim_pkg::DATA_W-1:0] qx);
        ordinate_t   answer;
        int unsigned n;
        int unsigned last;
        int unsigned j;
        longint      x;
        longint      xj;
        longint      xk;
        longint      yj;
        longint      yk;
        longint      num;
        longint      den;
        longint      ratio;
        longint      prod;
        if (c == plim_pkg::CMD_LOAD)
        begin
            knot_x[idx] = px;
            knot_y[idx] = py;
            return;
        end
        n = (point_count > plim_pkg::DEF_MAX_POINTS) ? plim_pkg::DEF_MAX_POINTS : point_count;
        answer.empty = 1'b0;
        if (n == 0)
        begin
            answer.value = '0;
            answer.seg   = '0;
            answer.empty = 1'b1;
            expected_ordinates.push_back(answer);
            return;
        end
        x    = longint'(qx);
        last = n - 1;
        if (x <= longint'(knot_x[0]))
        begin
            answer.value = knot_y[0];
            j = 0;
        end
        else if (x >= longint'(knot_x[last]))
        begin
            answer.value = knot_y[last];
            j = last;
        end
        else
        begin
            j = (segment_hint > last) ? last : segment_hint;
            while (j > 0 && x < longint'(knot_x[j]))
                j--;
            while (j < last && x > longint'(knot_x[j + 1]))
                j++;
            xj  = longint'(knot_x[j]);
            xk  = longint'(knot_x[j + 1]);
            yj  = longint'(knot_y[j]);
            yk  = longint'(knot_y[j + 1]);
            num = x - xj;
            den = xk - xj;
            if (num <= 0 || den <= 0)
                ratio = 0;
            else if (num >= den)
                ratio = 65536;
            else
                ratio = (num <<< plim_pkg::FRAC_W) / den;
            prod = ratio * (yk - yj);
            answer.value = plim_pkg::DATA_W'(yj + (prod >>> plim_pkg::FRAC_W));
        end
        answer.seg   = plim_pkg::IDX_W'(j);
        segment_hint = j;
        expected_ordinates.push_back(answer);
    endfunction

    function void check_result(input logic signed [plim_pkg::DATA_W-1:0] value,
                               input logic [plim_pkg::IDX_W-1:0] seg, input logic empty);
        ordinate_t answer;
        if (expected_ordinates.size() == 0)
        begin
            if (mismatches < 10)
                $display("ERROR: result with no query waiting: value_y=%0d segment=%0d empty_res=%0b",
                         value, seg, empty);
            mismatches++;
            return;
        end
        answer = expected_ordinates.pop_front();
        if (value !== answer.value || seg !== answer.seg || empty !== answer.empty)
        begin
            if (mismatches < 10)
                $display("ERROR: result differs: expected value_y=%0d segment=%0d empty_res=%0b, %s",
                         answer.value, answer.seg, answer.empty,
                         $sformatf("got value_y=%0d segment=%0d empty_res=%0b", value, seg, empty));
            mismatches++;
        end
    endfunction

endclass

module piecewise_linear_interpolator_test;

    import plim_pkg::*;

    localparam int CAPACITY    = DEF_MAX_POINTS;
    localparam int COUNT_MAX   = (1 << CNT_W) - 1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int MODE_ITEMS  = 260;
    localparam int FULL_LOADED = 64;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic        [CNT_W-1:0]  cfg_data    = '0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic                     cmd         = CMD_LOAD;
    logic        [IDX_W-1:0]  point_index = '0;
    logic signed [DATA_W-1:0] point_x     = '0;
    logic signed [DATA_W-1:0] point_y     = '0;
    logic signed [DATA_W-1:0] query_x     = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic signed [DATA_W-1:0] value_y;
    logic        [IDX_W-1:0]  segment;
    logic                     empty_res;

    ordinate_scoreboard record = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;
    int mode_start;

    piecewise_linear_interpolator DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .point_index(point_index),
        .point_x    (point_x),
        .point_y    (point_y),
        .query_x    (query_x),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_y    (value_y),
        .segment    (segment),
        .empty_res  (empty_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            record.check_result(value_y, segment, empty_res);
    end

    task automatic send_item(input logic c, input logic [IDX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] px,
                             input logic signed [DATA_W-1:0] py,
                             input logic signed [DATA_W-1:0] qx);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        cmd         = c;
        point_index = idx;
        point_x     = px;
        point_y     = py;
        query_x     = qx;
        do
            @(posedge clk);
        while (in_stall);
        record.note_input(c, idx, px, py, qx);
        items_sent++;
    endtask

    task automatic load_point(input int idx, input logic signed [DATA_W-1:0] px,
                              input logic signed [DATA_W-1:0] py);
        send_item(CMD_LOAD, IDX_W'(idx), px, py, $urandom);
    endtask

    task automatic query_at(input logic signed [DATA_W-1:0] qx);
        send_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom, qx);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (record.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_count(input int unsigned count);
        wait_drained();
        repeat (8) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = CNT_W'(count);
        do
            @(posedge clk);
        while (!cfg_ready);
        record.set_count(count);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_query_x(input int n);
        int     k;
        longint lo;
        longint hi;
        if (n == 0)
            return $urandom;
        k  = (n > 1) ? $urandom_range(0, n - 2) : 0;
        lo = longint'(record.knot_x[k]);
        hi = longint'(record.knot_x[(n > 1) ? k + 1 : k]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return record.knot_x[$urandom_range(0, n - 1)];
            4, 5, 6, 7: return (hi > lo) ? DATA_W'(lo + longint'($urandom_range(0, 32'(hi - lo))))
                                         : DATA_W'(lo);
            8:          return $urandom;
            default:    return $urandom_range(0, 1) ? record.knot_x[0] - 1
                                                    : record.knot_x[n - 1] + 1;
        endcase
    endfunction

    // Stays at or below the last low entry, so the walk never leaves the loaded entries.
    function automatic logic signed [DATA_W-1:0] pick_low_x();
        int     k;
        longint lo;
        longint hi;
        k  = $urandom_range(0, FULL_LOADED - 2);
        lo = longint'(record.knot_x[k]);
        hi = longint'(record.knot_x[k + 1]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return record.knot_x[$urandom_range(0, FULL_LOADED - 1)];
            4, 5, 6, 7: return (hi > lo) ? DATA_W'(lo + longint'($urandom_range(0, 32'(hi - lo))))
                                         : DATA_W'(lo);
            default:    return record.knot_x[0] - 1;
        endcase
    endfunction

    task automatic run_directed();
        write_count(0);
        query_at(32'h8000_0000);
        query_at(32'h7FFF_FFFF);
        write_count(1);
        load_point(0, 32'h8000_0000, 32'h7FFF_FFFF);
        query_at(32'h0000_0000);
        query_at(32'h8000_0000);
        load_point(1, -32'sh0001_0000, 32'h8000_0000);
        load_point(2, -32'sh0001_0000, 32'h0003_0000);
        load_point(3, 32'h0005_0000, 32'hFFFF_8000);
        load_point(4, 32'h0002_0000, 32'h7FFF_FFFF);
        load_point(5, 32'h7FFF_FFFF, 32'h1234_5678);
        write_count(2);
        query_at(32'h7FFF_FFFF);
        write_count(6);
        query_at(-32'sh0001_0000);
        query_at(32'hC000_0000);
        query_at(-32'sh0001_0000);
        query_at(32'h0001_0000);
        query_at(32'h7FFF_0000);
        query_at(32'h7FFF_FFFF);
        query_at(32'h0004_0000);
        write_count(4);
        query_at(32'h0001_0000);
        load_point(CAPACITY - 1, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    task automatic run_phase(input bit pressure);
        int          n;
        int          pick;
        int          total;
        int          base;
        int          held;
        bit          narrow_y;
        int unsigned span;
        int          xs [$];
        pick = $urandom_range(0, 99);
        if (pressure)
            n = $urandom_range(2, 12);
        else if (pick < 5)
            n = 0;
        else if (pick < 15)
            n = 1;
        else if (pick < 85)
            n = $urandom_range(2, 12);
        else
            n = $urandom_range(13, 64);
        write_count(n);
        case ($urandom_range(0, 2))
            0:       span = 32'h0003_FFFF;
            1:       span = 32'h0FFF_FFFF;
            default: span = 32'hFFFF_FFFF;
        endcase
        base     = (span == 32'hFFFF_FFFF) ? 32'h8000_0000 : (int'($urandom) >>> 1);
        narrow_y = $urandom_range(0, 1);
        for (int i = 0; i < n; i++)
            xs.push_back(base + int'($urandom_range(0, span)));
        xs.sort();
        for (int i = 1; i < n; i++)
            if ($urandom_range(0, 9) == 0)
                xs[i] = xs[i - 1];
        if (n > 1 && $urandom_range(0, 9) == 0)
        begin
            pick          = $urandom_range(0, n - 2);
            held          = xs[pick];
            xs[pick]      = xs[pick + 1];
            xs[pick + 1]  = held;
        end
        for (int i = 0; i < n; i++)
            load_point(i, xs[i], narrow_y ? int'($urandom_range(0, 32'h7FFFF)) - 32'h40000
                                          : $urandom);
        total = $urandom_range(6, 24);
        for (int k = 0; k < total; k++)
        begin
            if (pressure && k == 1)
                hold_left = HOLD_CYCLES;
            if (pressure && k == total - 3)
                wait_drained();
            if ($urandom_range(0, 99) < 15)
                load_point((n > 0 && $urandom_range(0, 1)) ? $urandom_range(0, n - 1)
                                                           : $urandom_range(0, CAPACITY - 1),
                           $urandom, $urandom);
            else
                query_at(pick_query_x(n));
        end
    endtask

    // The count covers or exceeds the whole table, but only the low entries and the last entry are
    // loaded; queries stay among the low entries but for one clamp at the last point, before the count drops to 3.
    task automatic run_full_table();
        int xs [$];
        for (int i = 0; i < FULL_LOADED; i++)
            xs.push_back(int'($urandom) >>> 1);
        xs.sort();
        write_count(CAPACITY);
        for (int i = 0; i < FULL_LOADED; i++)
            load_point(i, xs[i], $urandom);
        load_point(CAPACITY - 1, 32'h7FFF_FFFF, $urandom);
        for (int k = 0; k < 12; k++)
            query_at(pick_low_x());
        write_count(COUNT_MAX);
        for (int k = 0; k < 6; k++)
            query_at(pick_low_x());
        write_count(CAPACITY + 1 + $urandom_range(0, 900));
        for (int k = 0; k < 4; k++)
            query_at(pick_low_x());
        query_at(32'h7FFF_FFFF);
        write_count(3);
        for (int k = 0; k < 4; k++)
            query_at(pick_query_x(3));
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        run_directed();
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 78 : 0;
            recv_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 19 : 0;
            mode_start    = items_sent;
            run_phase(1'b1);
            while (items_sent - mode_start < MODE_ITEMS)
                run_phase(1'b0);
        end
        run_full_table();
        wait_drained();
        repeat (20) @(posedge clk);
        if (record.mismatches == 0 && record.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
